// ----- hw/rtl/min_heap_build_swap_log_macros.svh -----
// Assertion macros for the checker file.
`ifndef MIN_HEAP_BUILD_SWAP_LOG_MACROS_SVH
`define MIN_HEAP_BUILD_SWAP_LOG_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHB_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mhb check failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define MHB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mhb check failed: next-cycle rule");

`endif

// ----- hw/rtl/mhb_pkg.sv -----
// Types and constants shared by the heap build block.
package mhb_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int VAL_W       = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_item;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] swap_parent;
    logic [IDX_W-1:0] swap_child;
    logic             swap_valid;
    logic             last_swap;
    logic             overflowed;
  } result_t;

  // Classified beat handed from front to back.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        idx;
    logic                    wr;
    logic                    last;
    logic [CNT_W-1:0]        n;
    logic                    ovf;
  } cmd_t;

endpackage

// ----- hw/rtl/mhb_fifo.sv -----
// Small first-in first-out queue with push/full and pop/empty sides.
module mhb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    if (p == PW'(DEPTH - 1)) q = '0;
    else q = p + PW'(1);
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wrap_inc(wptr);
      if (do_pop) rptr <= wrap_inc(rptr);
      if (do_push && !do_pop) fill <= fill + CW'(1);
      else if (do_pop && !do_push) fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wdata;
  end

endmodule

// ----- hw/rtl/mhb_front.sv -----
// Front end: counts elements, flags drops and tags the closing beat.
module mhb_front
  import mhb_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_push,
  output cmd_t  cmd,
  input  logic  cmd_full
);

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             fits;

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;
  assign fits     = (count < CNT_W'(CAPACITY));

  always_comb begin
    cmd.value = item.value;
    cmd.idx   = count[IDX_W-1:0];
    cmd.wr    = fits;
    cmd.last  = item.last_item;
    cmd.n     = fits ? count + CNT_W'(1) : count;
    cmd.ovf   = ovf || !fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd_push) begin
      if (item.last_item) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (fits) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/mhb_back.sv -----
// Back end: element store and the sift-down sequencer that logs swaps.
module mhb_back
  import mhb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  input  cmd_t    cmd,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  typedef enum logic [2:0] {
    B_LOAD, B_RDI, B_HOLD, B_RDL, B_GETL, B_GETR, B_DEC, B_END
  } bstate_t;

  bstate_t state;

  logic signed [VAL_W-1:0] mem [STORE_DEPTH];
  logic signed [VAL_W-1:0] rdata;
  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    we;

  logic [CNT_W-1:0]        n;
  logic                    ovf;
  logic [IDX_W-1:0]        node;
  logic [IDX_W-1:0]        i;
  logic signed [VAL_W-1:0] hold;
  logic signed [VAL_W-1:0] lval;
  logic signed [VAL_W-1:0] rval;
  logic                    lok;
  logic                    rok;
  result_t                 pend;
  logic                    pend_valid;

  logic [IDX_W+1:0]        lidx;
  logic [IDX_W+1:0]        ridx;
  logic                    take_l;
  logic                    take_r;
  logic                    swap;
  logic signed [VAL_W-1:0] cand;
  logic [IDX_W-1:0]        best;
  logic signed [VAL_W-1:0] best_val;
  logic                    stall;

  assign lidx = {1'b0, i, 1'b1};
  assign ridx = lidx + (IDX_W+2)'(1);

  // smaller child, left wins ties, swap only when strictly below the node
  always_comb begin
    take_l   = lok && (lval < hold);
    cand     = take_l ? lval : hold;
    take_r   = rok && (rval < cand);
    swap     = take_l || take_r;
    best     = take_r ? ridx[IDX_W-1:0] : (take_l ? lidx[IDX_W-1:0] : i);
    best_val = take_r ? rval : cand;
    stall    = swap && pend_valid && res_full;
  end

  always_comb begin
    cmd_pop  = (state == B_LOAD) && !cmd_empty;
    raddr    = i;
    we       = 1'b0;
    waddr    = i;
    wdata    = hold;
    res_push = 1'b0;
    res      = pend;
    case (state)
      B_LOAD: begin
        we    = cmd_pop && cmd.wr;
        waddr = cmd.idx;
        wdata = cmd.value;
      end
      B_RDL:  raddr = lidx[IDX_W-1:0];
      B_GETL: raddr = ridx[IDX_W-1:0];
      B_DEC: begin
        if (!stall) begin
          we = 1'b1;
          if (swap) begin
            wdata    = best_val;
            res_push = pend_valid;
          end
        end
      end
      B_END: begin
        res_push = !res_full;
        if (pend_valid) begin
          res.last_swap = 1'b1;
        end else begin
          res.swap_parent = '0;
          res.swap_child  = '0;
          res.swap_valid  = 1'b0;
          res.last_swap   = 1'b1;
          res.overflowed  = ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_LOAD;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        B_LOAD: begin
          if (cmd_pop && cmd.last) begin
            n          <= cmd.n;
            ovf        <= cmd.ovf;
            node       <= cmd.n[CNT_W-1:1];
            i          <= cmd.n[CNT_W-1:1];
            pend_valid <= 1'b0;
            state      <= B_RDI;
          end
        end
        B_RDI:  state <= B_HOLD;
        B_HOLD: begin
          hold  <= rdata;
          state <= B_RDL;
        end
        B_RDL: begin
          lok   <= (lidx < {1'b0, n});
          rok   <= (ridx < {1'b0, n});
          state <= (lidx < {1'b0, n}) ? B_GETL : B_DEC;
        end
        B_GETL: begin
          lval  <= rdata;
          state <= rok ? B_GETR : B_DEC;
        end
        B_GETR: begin
          rval  <= rdata;
          state <= B_DEC;
        end
        B_DEC: begin
          if (!stall) begin
            if (swap) begin
              // node value rides down in hold; written once the sift stops
              pend.swap_parent <= i;
              pend.swap_child  <= best;
              pend.swap_valid  <= 1'b1;
              pend.last_swap   <= 1'b0;
              pend.overflowed  <= ovf;
              pend_valid       <= 1'b1;
              i                <= best;
              state            <= B_RDL;
            end else if (node == '0) begin
              state <= B_END;
            end else begin
              node  <= node - IDX_W'(1);
              i     <= node - IDX_W'(1);
              state <= B_RDI;
            end
          end
        end
        B_END: begin
          if (!res_full) begin
            pend_valid <= 1'b0;
            state      <= B_LOAD;
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

endmodule

// ----- hw/rtl/min_heap_build_swap_log.sv -----
// Top level: Floyd min-heap build over a loaded set, logging every swap.
//
//   channel  handshake           payload
//   item     push / full         item_t   (value, last_item)
//   result   empty / pop         result_t (swap_parent, swap_child, swap_valid,
//                                          last_swap, overflowed)
//
// Loading takes one beat per cycle through a two-entry queue to the store
// while the back end waits for beats. After the closing beat the build runs:
// the sift-down sequencer reads each node, then its children, through the
// single-port store read. Beats of the next set queue up meanwhile; the back
// end takes them after the final result is queued. Result queue full stalls
// the sequencer. Synchronous active-high reset; the store needs no clearing.
module min_heap_build_swap_log
  import mhb_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic                   cmd_push;
  cmd_t                   cmd_in;
  logic                   cmd_full;
  logic [$bits(cmd_t)-1:0] cmd_vec;
  cmd_t                   cmd_out;
  logic                   cmd_empty;
  logic                   cmd_pop;
  logic                   res_push;
  result_t                res_in;
  logic                   res_full;
  logic [$bits(result_t)-1:0] res_vec;

  mhb_front #(.CAPACITY(CAPACITY)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  mhb_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_vec),
    .empty (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_vec);

  mhb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  mhb_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_vec),
    .empty (empty)
  );

  assign result = result_t'(res_vec);

endmodule

// ----- hw/rtl/mhb_checker.sv -----
// Port-level checks on the heap build block, bound to the top level.
`include "min_heap_build_swap_log_macros.svh"

module mhb_checker
  import mhb_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input item_t   item,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // a waiting result beat stays put until taken
  `MHB_ASSERT_NEXT(a_res_hold, clk, rst, !empty && !pop, !empty && $stable(result))

  // a no-swap beat is always the closing one
  `MHB_ASSERT_NOW(a_noswap_last, clk, rst, !empty, result.swap_valid || result.last_swap)

  // a no-swap beat carries zero indices
  `MHB_ASSERT_NOW(a_noswap_zero, clk, rst, !empty && !result.swap_valid, result.swap_parent == '0 && result.swap_child == '0)

  // a swap always pairs a node with one of its own children
  `MHB_ASSERT_NOW(a_swap_child, clk, rst, !empty && result.swap_valid, ({1'b0, result.swap_child} == {result.swap_parent, 1'b1}) || ({1'b0, result.swap_child} == ({result.swap_parent, 1'b0} + 7'd2)))

endmodule

bind min_heap_build_swap_log mhb_checker u_mhb_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the heap build block with a swap log.
`timescale 1ns / 1ps

module testbench;
  import mhb_pkg::*;

  localparam int HEAP_CAP = 64;
  localparam int MAX_SWAPS = 64;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  // predictor state
  logic signed [VAL_W-1:0] heap_mem [HEAP_CAP];
  int      heap_len;
  bit      heap_ovf;
  result_t swap_q [$];

  dir_row_t dir_rows [$];
  bit      rx_steady;
  bit      tx_steady;
  int      mismatches;
  int      swaps_checked;
  int      items_sent;
  int      sets_done;
  int      ovf_sets;

  min_heap_build_swap_log #(.CAPACITY(HEAP_CAP)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t mk_res(int p, int c, bit sv, bit ls, bit ov);
    result_t r;
    r.swap_parent = p[IDX_W-1:0];
    r.swap_child  = c[IDX_W-1:0];
    r.swap_valid  = sv;
    r.last_swap   = ls;
    r.overflowed  = ov;
    return r;
  endfunction

  // appends one awaited result beat to the tail of the log
  function automatic void queue_beat(input result_t r);
    swap_q = {swap_q, r};
  endfunction

  // Adds an item; at the close queues a typed beat or the Floyd swap log in order.
  task automatic heap_accept(input item_t it, input bit typed, input result_t typed_res);
    int node;
    int i;
    int best;
    int l;
    int r;
    int nsw;
    bit done;
    bit have_held;
    result_t held;
    logic signed [VAL_W-1:0] t;
    if (heap_len < HEAP_CAP) begin
      heap_mem[heap_len] = it.value;
      heap_len++;
    end else begin
      heap_ovf = 1'b1;
    end
    if (!it.last_item) return;
    if (heap_ovf) ovf_sets++;
    if (typed) begin
      queue_beat(typed_res);
    end else begin
      nsw = 0;
      have_held = 1'b0;
      for (node = heap_len / 2; node >= 0; node--) begin
        i = node;
        done = 1'b0;
        while (!done) begin
          best = i;
          l = 2 * i + 1;
          r = 2 * i + 2;
          if (l < heap_len && heap_mem[l] < heap_mem[best]) best = l;
          if (r < heap_len && heap_mem[r] < heap_mem[best]) best = r;
          if (best == i) begin
            done = 1'b1;
          end else begin
            t = heap_mem[i];
            heap_mem[i] = heap_mem[best];
            heap_mem[best] = t;
            if (nsw < MAX_SWAPS) begin
              if (have_held) queue_beat(held);
              held = mk_res(i, best, 1'b1, 1'b0, heap_ovf);
              have_held = 1'b1;
            end
            nsw++;
            i = best;
          end
        end
      end
      if (!have_held) held = mk_res(0, 0, 1'b0, 1'b0, heap_ovf);
      held.last_swap = 1'b1;
      queue_beat(held);
    end
    heap_len = 0;
    heap_ovf = 1'b0;
    sets_done++;
  endtask

  task automatic add_row(input int v, input bit l, input bit typed = 1'b0, input int p = 0,
                         input int c = 0, input bit sv = 1'b0, input bit ls = 1'b0);
    dir_row_t row;
    row.it.value     = v;
    row.it.last_item = l;
    row.typed        = typed;
    row.res          = mk_res(p, c, sv, ls, 1'b0);
    dir_rows = {dir_rows, row};
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] draw_value(int mode);
    int m;
    m = (mode == 3) ? $urandom_range(0, 2) : mode;
    case (m)
      0: return $urandom;
      1: return int'($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // Drives one beat from the falling edge; returns at the edge that takes it.
  task automatic send_beat(input item_t it, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (swap_q.size() == 0) begin
        $display("%0t ns: unexpected result beat, got parent %0d child %0d valid %0b",
                 $time, result.swap_parent, result.swap_child, result.swap_valid);
        mismatches++;
      end else begin
        check_field("swap_parent", swap_q[0].swap_parent, result.swap_parent);
        check_field("swap_child",  swap_q[0].swap_child,  result.swap_child);
        check_field("swap_valid",  swap_q[0].swap_valid,  result.swap_valid);
        check_field("last_swap",   swap_q[0].last_swap,   result.last_swap);
        check_field("overflowed",  swap_q[0].overflowed,  result.overflowed);
        void'(swap_q.pop_front());
        swaps_checked++;
      end
    end
  end

  // Result side: random stalls, short mostly, the odd long one.
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!rx_steady && $urandom_range(0, 5) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", swap_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int set_idx;
    int n;
    int mode;
    item_t it;
    result_t none;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    heap_len = 0;
    heap_ovf = 1'b0;
    mismatches = 0;
    swaps_checked = 0;
    items_sent = 0;
    sets_done = 0;
    ovf_sets = 0;
    none = '0;

    // single element: nothing to sift
    add_row(0, 1'b1, 1'b1, 0, 0, 1'b0, 1'b1);
    // extremes already in order, then reversed
    add_row(32'h8000_0000, 1'b0);
    add_row(32'h7fff_ffff, 1'b1, 1'b1, 0, 0, 1'b0, 1'b1);
    add_row(32'h7fff_ffff, 1'b0);
    add_row(32'h8000_0000, 1'b1, 1'b1, 0, 1, 1'b1, 1'b1);
    // equal values do not swap
    add_row(5, 1'b0);
    add_row(5, 1'b1, 1'b1, 0, 0, 1'b0, 1'b1);
    // equal children: left one is taken
    add_row(9, 1'b0);
    add_row(4, 1'b0);
    add_row(4, 1'b1, 1'b1, 0, 1, 1'b1, 1'b1);
    // right child smaller
    add_row(9, 1'b0);
    add_row(7, 1'b0);
    add_row(2, 1'b1, 1'b1, 0, 2, 1'b1, 1'b1);
    // strictly descending: deep sifts
    for (int k = 7; k >= 1; k--) add_row(k * 10, k == 1);
    add_row(1, 1'b0);
    add_row(-1, 1'b0);
    add_row(32'h5555_5555, 1'b0);
    add_row(32'haaaa_aaaa, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].it, pick_gap());
      heap_accept(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
    end

    set_idx = 0;
    while (items_sent < 310) begin
      rx_steady = ($urandom_range(0, 3) == 0);
      tx_steady = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 3);
      case (set_idx)
        0: n = HEAP_CAP + 2;
        1: n = HEAP_CAP;
        default: begin
          case ($urandom_range(0, 99)) inside
            [0:69]:  n = $urandom_range(1, 10);
            [70:87]: n = $urandom_range(11, 30);
            [88:95]: n = $urandom_range(31, HEAP_CAP);
            default: n = $urandom_range(HEAP_CAP + 1, HEAP_CAP + 4);
          endcase
        end
      endcase
      // last set is trimmed so the run stays near its item budget
      if (n > 310 - items_sent) n = 310 - items_sent;
      for (int k = 0; k < n; k++) begin
        it.value = draw_value(mode);
        it.last_item = (k == n - 1);
        send_beat(it, pick_gap());
        heap_accept(it, 1'b0, none);
      end
      // hold the sender until the whole swap log has drained
      if (set_idx == 4) begin
        @(negedge clk);
        push <= 1'b0;
        while (swap_q.size() != 0) @(posedge clk);
      end
      set_idx++;
    end
    @(negedge clk);
    push <= 1'b0;

    rx_steady = 1'b0;
    while (swap_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d sets built from %0d elements, %0d with dropped elements",
             sets_done, items_sent, ovf_sets);
    $display("%0d swap log beats checked, %0d mismatches", swaps_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mhb_pkg.sv
hw/rtl/mhb_fifo.sv
hw/rtl/mhb_front.sv
hw/rtl/mhb_back.sv
hw/rtl/min_heap_build_swap_log.sv
hw/rtl/mhb_checker.sv
verif/testbench.sv
